FILE: rtl/core/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types and constants for the counted insertion sorter.
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int VAL_W            = 32;
  localparam int CMP_W            = 11;
  localparam int MOV_W            = 12;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_SETTLE,
    ST_DRAIN
  } state_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctrl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                    valid;
    logic                    take;
    logic signed [VAL_W-1:0] value;
  } cell_link_t;

endpackage

FILE: rtl/core/isc_cell.sv
// ----------------------------------------------------------------------------
// isc_cell
// One slot of the sorting chain: holds one element, shifts right on insert,
// shifts left on drain.
// ----------------------------------------------------------------------------
module isc_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  isc_pkg::cell_ctrl_t                 ctrl,
  input  logic signed [isc_pkg::VAL_W-1:0]    ins_value,
  input  isc_pkg::cell_link_t                 left_i,
  input  isc_pkg::cell_link_t                 right_i,
  output isc_pkg::cell_link_t                 link_o,
  output logic                                ins_here_o
);

  logic                               valid_r, valid_nxt;
  logic signed [isc_pkg::VAL_W-1:0]   value_r, value_nxt;
  logic                               take;

  // a cell gives way when it is empty or holds a strictly larger value
  assign take       = !valid_r || (value_r > ins_value);
  assign ins_here_o = take && !left_i.take;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctrl.insert) begin
      valid_nxt = valid_r | left_i.valid;
      if (take) begin
        value_nxt = left_i.take ? left_i.value : ins_value;
      end
    end else if (ctrl.drain) begin
      valid_nxt = right_i.valid;
      value_nxt = right_i.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign link_o = '{valid: valid_r, take: take, value: value_r};

endmodule

FILE: rtl/core/isc_count.sv
// ----------------------------------------------------------------------------
// isc_count
// Comparison and move counters, updated in the cycle after each insert into a
// non-empty chain from the registered insert position.
// ----------------------------------------------------------------------------
module isc_count #(
  parameter int MAX_ELEMENTS = isc_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  insert,
  input  logic [$clog2(MAX_ELEMENTS)-1:0]       pos,
  input  logic [$clog2(MAX_ELEMENTS+1)-1:0]     held,
  input  logic                                  clr,
  output logic [isc_pkg::CMP_W-1:0]             compare_count,
  output logic [isc_pkg::MOV_W-1:0]             move_count
);

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS+1);

  logic                          pend_r;
  logic [IDX_W-1:0]              pos_r;
  logic [CNT_W-1:0]              held_r;
  logic [CNT_W-1:0]              shifted;
  logic [isc_pkg::CMP_W-1:0]     cmp_r, cmp_nxt;
  logic [isc_pkg::MOV_W-1:0]     mov_r, mov_nxt;

  // elements strictly greater than the new one
  assign shifted = held_r - CNT_W'(pos_r);

  always_comb begin
    cmp_nxt = cmp_r;
    mov_nxt = mov_r;
    priority if (clr) begin
      cmp_nxt = '0;
      mov_nxt = '0;
    end else if (pend_r && (held_r != '0)) begin
      cmp_nxt = cmp_r + isc_pkg::CMP_W'(shifted)
              + isc_pkg::CMP_W'(pos_r != '0);
      mov_nxt = mov_r + isc_pkg::MOV_W'(shifted) + isc_pkg::MOV_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      cmp_r  <= '0;
      mov_r  <= '0;
    end else begin
      pend_r <= insert;
      cmp_r  <= cmp_nxt;
      mov_r  <= mov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos;
    held_r <= held;
  end

  assign compare_count = cmp_r;
  assign move_count    = mov_r;

endmodule

FILE: rtl/core/insertion_sort_counted_top.sv
// ----------------------------------------------------------------------------
// insertion_sort_counted_top
// Streaming insertion sorter on a chain of compare-and-shift cells, with
// comparison and move counters for each set.
// ----------------------------------------------------------------------------
//   channel | ports                                   | dir
//   --------+-----------------------------------------+-----
//   in      | in_valid/in_ready, sample_value, eos    | in
//   out     | out_valid/out_ready, sorted_value,      | out
//           | final_result, compare_count, move_count |
//
// One element is inserted per cycle while filling: every cell compares in
// parallel and the larger values shift one cell right.
// A set of n elements then passes a settle state for the counters and leaves
// in n output transactions, cell 0 being the output register; the chain shifts
// left on each output transaction. Input is stalled from the last element until
// the final result is taken. Reset clears the cell valid bits and counters.
// ----------------------------------------------------------------------------
module insertion_sort_counted_top #(
  parameter int MAX_ELEMENTS = isc_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [isc_pkg::VAL_W-1:0]    in_sample_value,
  input  logic                                in_end_of_set,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [isc_pkg::VAL_W-1:0]    out_sorted_value,
  output logic                                out_final_result,
  output logic [isc_pkg::CMP_W-1:0]           out_compare_count,
  output logic [isc_pkg::MOV_W-1:0]           out_move_count
);

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS+1);

  isc_pkg::state_t      state_r, state_nxt;
  isc_pkg::cell_ctrl_t  ctrl;
  isc_pkg::cell_link_t  link_w [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] ins_here;
  logic [IDX_W-1:0]     pos;
  logic [CNT_W-1:0]     held_r, held_nxt;
  logic                 in_acc, out_acc, last_in, clr;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign last_in = in_end_of_set || (held_r == CNT_W'(MAX_ELEMENTS - 1));

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    ctrl.insert = 1'b0;
    ctrl.drain  = 1'b0;
    clr         = 1'b0;
    held_nxt    = held_r;
    unique case (state_r)
      isc_pkg::ST_FILL: begin
        in_ready    = 1'b1;
        ctrl.insert = in_valid;
        if (in_valid) begin
          held_nxt = held_r + CNT_W'(1);
          if (last_in) begin
            state_nxt = isc_pkg::ST_SETTLE;
          end
        end
      end
      isc_pkg::ST_SETTLE: begin
        state_nxt = isc_pkg::ST_DRAIN;
      end
      isc_pkg::ST_DRAIN: begin
        out_valid  = 1'b1;
        ctrl.drain = out_ready;
        if (out_ready && out_final_result) begin
          clr       = 1'b1;
          held_nxt  = '0;
          state_nxt = isc_pkg::ST_FILL;
        end
      end
      default: begin
        state_nxt = isc_pkg::ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= isc_pkg::ST_FILL;
      held_r  <= '0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
    end
  end

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    isc_pkg::cell_link_t left_l, right_l;
    if (i == 0) begin : g_head
      assign left_l = '{valid: 1'b1, take: 1'b0, value: '0};
    end else begin : g_left
      assign left_l = link_w[i-1];
    end
    if (i == MAX_ELEMENTS - 1) begin : g_tail
      assign right_l = '{valid: 1'b0, take: 1'b1, value: '0};
    end else begin : g_right
      assign right_l = link_w[i+1];
    end
    isc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .ins_value  (in_sample_value),
      .left_i     (left_l),
      .right_i    (right_l),
      .link_o     (link_w[i]),
      .ins_here_o (ins_here[i])
    );
  end

  // insert point is one-hot, so an OR of the indexes encodes it
  always_comb begin
    pos = '0;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      if (ins_here[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

  isc_count #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_count (
    .clk           (clk),
    .rst_n         (rst_n),
    .insert        (in_acc),
    .pos           (pos),
    .held          (held_r),
    .clr           (clr),
    .compare_count (out_compare_count),
    .move_count    (out_move_count)
  );

  assign out_sorted_value = link_w[0].value;
  assign out_final_result = link_w[0].valid && !link_w[1].valid;

`ifndef NO_ASSERTIONS
  a_drain_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> link_w[0].valid)
    else $error("output offered from an empty chain");

  a_one_insert_point: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == isc_pkg::ST_FILL) |-> $onehot(ins_here))
    else $error("insert point not unique");

  a_last_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && last_in) |=> !in_ready)
    else $error("input taken after last element");

  a_final_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_final_result) |=> (in_ready && (held_r == '0)))
    else $error("sorter not ready after final result");
`endif

endmodule

FILE: test/insertion_sort_counted_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sort_counted_top_test
// Self-checking bench for the counted insertion sorter: sets of signed
// values go in, each burst of sorted results is checked value by value along
// with the final flag and the comparison and move counts of the set.
// ----------------------------------------------------------------------------
module insertion_sort_counted_top_test;

  localparam int STORE_DEPTH = isc_pkg::MAX_ELEMENTS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 20;

  typedef logic signed [isc_pkg::VAL_W-1:0] sample_t;

  typedef struct {
    sample_t                   value;
    logic                      last_flag;
    logic [isc_pkg::CMP_W-1:0] compares;
    logic [isc_pkg::MOV_W-1:0] moves;
  } sorted_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  sample_t                   in_sample_value;
  logic                      in_end_of_set;
  logic                      out_valid;
  logic                      out_ready;
  sample_t                   out_sorted_value;
  logic                      out_final_result;
  logic [isc_pkg::CMP_W-1:0] out_compare_count;
  logic [isc_pkg::MOV_W-1:0] out_move_count;

  // predictor state
  sample_t                   sort_list[$];
  logic [isc_pkg::CMP_W-1:0] compare_sum;
  logic [isc_pkg::MOV_W-1:0] move_sum;
  sorted_result_t            pending_sorted[$];

  int error_count;
  int samples_sent;
  int results_seen;
  int sets_flushed;
  int cycle_count;
  bit idling_on;
  int out_hold_cycles;

  insertion_sort_counted_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_value   (in_sample_value),
    .in_end_of_set     (in_end_of_set),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sorted_value  (out_sorted_value),
    .out_final_result  (out_final_result),
    .out_compare_count (out_compare_count),
    .out_move_count    (out_move_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("insertion_sort_counted_top regression: fail");
      $finish;
    end
  end

  // Insert one accepted sample; on end of set or a full store, queue the burst.
  task automatic insert_sample(input sample_t value, input logic marked);
    int held;
    int greater;
    held    = sort_list.size();
    greater = 0;
    foreach (sort_list[k]) begin
      if (sort_list[k] > value) greater++;
    end
    sort_list.insert(held - greater, value);
    if (held > 0) begin
      compare_sum = compare_sum + isc_pkg::CMP_W'(greater)
                  + isc_pkg::CMP_W'((greater < held) ? 1 : 0);
      move_sum    = move_sum + isc_pkg::MOV_W'(greater) + isc_pkg::MOV_W'(1);
    end
    if (marked || sort_list.size() == STORE_DEPTH) begin
      foreach (sort_list[k]) begin
        sorted_result_t r;
        r.value     = sort_list[k];
        r.last_flag = (k == sort_list.size() - 1);
        r.compares  = compare_sum;
        r.moves     = move_sum;
        pending_sorted.push_back(r);
      end
      sort_list.delete();
      compare_sum = '0;
      move_sum    = '0;
      sets_flushed++;
    end
  endtask

  // input monitor: outputs of the DUT are sampled before the edge updates them
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      insert_sample(in_sample_value, in_end_of_set);
      samples_sent++;
    end
  end

  always @(posedge clk) begin : check_result
    sorted_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_sorted.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %0d", $time,
                 out_sorted_value);
        error_count++;
      end else begin
        want = pending_sorted.pop_front();
        if (out_sorted_value !== want.value) begin
          $display("%0t: sorted_value mismatch, expected %0d, got %0d", $time,
                   want.value, out_sorted_value);
          error_count++;
        end
        if (out_final_result !== want.last_flag) begin
          $display("%0t: final_result mismatch, expected %0b, got %0b", $time,
                   want.last_flag, out_final_result);
          error_count++;
        end
        if (out_compare_count !== want.compares) begin
          $display("%0t: compare_count mismatch, expected %0d, got %0d", $time,
                   want.compares, out_compare_count);
          error_count++;
        end
        if (out_move_count !== want.moves) begin
          $display("%0t: move_count mismatch, expected %0d, got %0d", $time,
                   want.moves, out_move_count);
          error_count++;
        end
      end
    end
  end

  // result side: long hold-off first, then random stall bursts when enabled
  initial begin : result_ready_driver
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (out_hold_cycles > 0) begin
        out_hold_cycles--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input sample_t value, input logic marked);
    int gap;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_sample_value <= value;
    in_end_of_set   <= marked;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // pause until every queued result has come back
  task automatic wait_results_done();
    release_input();
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       pick_sample = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      1, 2, 3: pick_sample = $signed($urandom_range(0, 8)) - 4;
      default: pick_sample = $urandom;
    endcase
  endfunction

  task automatic send_random_set(input int len);
    for (int k = 0; k < len; k++) send_sample(pick_sample(), k == len - 1);
  endtask

  task automatic test_directed();
    sample_t mixed[$];
    // lone marked items
    send_sample(32'sd0, 1'b1);
    send_sample(32'sh80000000, 1'b1);
    // extremes, duplicates and signs in one set
    mixed = '{32'sh7fffffff, 32'sh80000000, -32'sd1, 32'sd0, 32'sd1, 32'sd1,
              -32'sd1, 32'sh80000000, 32'sh7fffffff, 32'sh55555555};
    foreach (mixed[k]) send_sample(mixed[k], k == mixed.size() - 1);
    // already ascending, then strictly descending
    for (int k = 0; k < 5; k++) send_sample(k * 1000 - 2000, k == 4);
    for (int k = 0; k < 5; k++) send_sample(2000 - k * 1000, k == 4);
    wait_results_done();
  endtask

  task automatic test_store_full();
    // descending fill without a marker: maximum counts, flush on the 64th
    for (int k = 0; k < STORE_DEPTH; k++) send_sample(32'sd5000 - k * 77, 1'b0);
    // random fill with the marker also on the 64th item
    for (int k = 0; k < STORE_DEPTH; k++) send_sample(pick_sample(), k == STORE_DEPTH - 1);
    wait_results_done();
  endtask

  task automatic test_random_sets(input int target);
    int sent;
    int len;
    sent = 0;
    while (sent < target) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      send_random_set(len);
      sent += len;
    end
  endtask

  task automatic test_output_hold();
    // output stalls long enough that the input backs up behind a full burst
    out_hold_cycles = 300;
    for (int k = 0; k < 5; k++) send_random_set($urandom_range(3, 6));
    wait_results_done();
  endtask

  task automatic test_no_idle();
    idling_on = 1'b0;
    test_random_sets(30);
    send_random_set(1);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_sample_value = '0;
    in_end_of_set   = 1'b0;
    compare_sum     = '0;
    move_sum        = '0;
    error_count     = 0;
    samples_sent    = 0;
    results_seen    = 0;
    sets_flushed    = 0;
    cycle_count     = 0;
    idling_on       = 1'b1;
    out_hold_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_store_full();
    test_random_sets(40);
    wait_results_done();
    test_output_hold();
    test_no_idle();
    wait_results_done();

    $display("covered %0d samples in %0d sets, %0d sorted results checked", samples_sent,
             sets_flushed, results_seen);
    $display("incl. full-store flushes, extremes, lone items and a long output stall");
    if (error_count == 0) begin
      $display("insertion_sort_counted_top regression: pass");
    end else begin
      $display("%0d mismatches", error_count);
      $display("insertion_sort_counted_top regression: fail");
    end
    $finish;
  end

endmodule
